// File: rtl/core/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int ADDR_W           = 48;
  localparam int SIZE_W           = 32;
  localparam int OFF_W            = 33;
  localparam int TOTAL_W          = 34;
  localparam int CFG_IDX_W        = 1;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 24;
  localparam logic [OFF_W-1:0] HEAP_BYTES_RESET = OFF_W'(1048576);

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_SPACE   = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_BYTES = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] length;
    logic [OFF_W-1:0]  start;
  } entry_t;

  // Finished transaction handed from the scan engine to the output stage
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic             grant;
    logic [OFF_W-1:0] start;
  } result_t;

endpackage

// File: rtl/core/ffba_ram.sv
// Generic single-port-write, registered-read RAM.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ffba_scan.sv
// Scan engine: block table memory, first-fit search, release lookup, append.
module ffba_scan #(
  parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [ffba_pkg::SIZE_W-1:0]   request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]   release_address,
  input  logic [ffba_pkg::ADDR_W-1:0]   heap_base,
  input  logic [ffba_pkg::OFF_W-1:0]    heap_bytes,
  output ffba_pkg::result_t             result,
  input  logic                          result_ack
);
  import ffba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0]  HDR_A   = ADDR_W'(HEADER_BYTES);
  localparam logic [TOTAL_W-1:0] HDR_T   = TOTAL_W'(HEADER_BYTES);

  state_t            state, state_next;
  logic              cmd;
  logic [OFF_W-1:0]  size;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0] target;
  logic [CNT_W-1:0]  rd_idx;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_idx;
  logic [CNT_W-1:0]  block_count;
  logic [OFF_W-1:0]  heap_top;
  status_t           res_status;
  logic              res_grant;
  logic [OFF_W-1:0]  res_start;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd_entry;

  logic              accept;
  logic [OFF_W-1:0]  size_in;
  logic              early;
  status_t           early_status;
  logic              hit;
  logic              issue;
  logic              scan_end;
  logic              no_room;
  logic [TOTAL_W:0]  top_sum;

  assign accept  = in_valid && in_ready;
  assign size_in = (OFF_W'(request_size) + OFF_W'(7)) & ~OFF_W'(7);

  // Requests that answer without touching the table
  always_comb begin
    early        = 1'b0;
    early_status = STAT_DONE;
    if (command == CMD_ALLOC) begin
      if (request_size == '0) begin
        early        = 1'b1;
        early_status = STAT_ZERO;
      end else if (size_in[OFF_W-1]) begin
        early        = 1'b1;
        early_status = STAT_SPACE;
      end
    end else if (release_address == '0) begin
      early = 1'b1;
    end
  end

  always_comb begin
    hit = 1'b0;
    if (chk_valid) begin
      if (cmd == CMD_ALLOC) begin
        hit = !rd_entry.busy && ({1'b0, rd_entry.length} >= size);
      end else begin
        hit = ADDR_W'(rd_entry.start) == target;
      end
    end
  end

  assign issue    = (state == ST_SCAN) && !hit && (rd_idx < block_count);
  assign scan_end = (state == ST_SCAN) && !hit && !chk_valid && !(rd_idx < block_count);
  assign top_sum  = (TOTAL_W+1)'(heap_top) + (TOTAL_W+1)'(total);
  assign no_room  = (block_count == CNT_MAX) || (top_sum > (TOTAL_W+1)'(heap_bytes));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = early ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (result_ack) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == ST_IDLE);
    result.valid     = (state == ST_DONE);
    result.status    = res_status;
    result.grant     = res_grant;
    result.start     = res_start;
    ram_we           = 1'b0;
    ram_waddr        = chk_idx;
    ram_wdata        = rd_entry;
    if (hit) begin
      ram_we         = 1'b1;
      ram_wdata.busy = (cmd == CMD_ALLOC);
    end else if (scan_end && cmd == CMD_ALLOC && !no_room) begin
      ram_we           = 1'b1;
      ram_waddr        = block_count[IDX_W-1:0];
      ram_wdata.busy   = 1'b1;
      ram_wdata.length = size[SIZE_W-1:0];
      ram_wdata.start  = heap_top;
    end
  end

  ffba_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chk_valid   <= 1'b0;
      block_count <= '0;
      heap_top    <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= issue;
      if (scan_end && cmd == CMD_ALLOC && !no_room) begin
        block_count <= block_count + CNT_W'(1);
        heap_top    <= top_sum[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= command;
      size       <= size_in;
      total      <= TOTAL_W'(size_in) + HDR_T;
      target     <= release_address - heap_base - HDR_A;
      rd_idx     <= '0;
      res_status <= early_status;
      res_grant  <= 1'b0;
      res_start  <= '0;
    end else begin
      if (issue) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        chk_idx <= rd_idx[IDX_W-1:0];
      end
      if (hit) begin
        res_status <= STAT_DONE;
        res_grant  <= (cmd == CMD_ALLOC);
        res_start  <= rd_entry.start;
      end else if (scan_end) begin
        if (cmd == CMD_RELEASE) begin
          res_status <= STAT_UNKNOWN;
        end else if (no_room) begin
          res_status <= STAT_SPACE;
        end else begin
          res_status <= STAT_DONE;
          res_grant  <= 1'b1;
          res_start  <= heap_top;
        end
      end
    end
  end

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: registers, scan engine, output stage.
//
//  Channel  Direction  Handshake               Payload
//  ------   ---------  ----------------------  -----------------------------------------
//  in       sink       in_valid / in_ready     command, request_size, release_address
//  out      source     out_valid / out_ready   payload_address, status
//  cfg      sink       cfg_we (no wait)        cfg_index, cfg_data
//
// One transaction at a time. A request that answers at once (zero size, oversize,
// release of address zero) goes straight from idle to done in the engine; a scan
// reads one entry per cycle from the registered-read table, up to block_count entries.
// The output register holds a finished result and frees the engine while it waits.
// Synchronous reset empties the table (count and heap top to zero) and restores the
// register defaults. A stalled output holds the engine in its done state, in_ready low.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [ffba_pkg::SIZE_W-1:0]      request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]      release_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ffba_pkg::ADDR_W-1:0]      payload_address,
  output logic [1:0]                       status,
  input  logic                             cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]      cfg_data
);
  import ffba_pkg::*;

  localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HEADER_BYTES);

  logic [ADDR_W-1:0] heap_base;
  logic [OFF_W-1:0]  heap_bytes;
  result_t           res;
  logic              res_ack;
  logic [ADDR_W-1:0] grant_addr;

  // Configuration registers; heap_bytes keeps the low 33 bits of the data
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= HEAP_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_BYTES: heap_bytes <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  ffba_scan #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .request_size    (request_size),
    .release_address (release_address),
    .heap_base       (heap_base),
    .heap_bytes      (heap_bytes),
    .result          (res),
    .result_ack      (res_ack)
  );

  // Payload address is always formed from the current base
  assign grant_addr = heap_base + ADDR_W'(res.start) + HDR_A;
  assign res_ack    = res.valid && (!out_valid || out_ready);

  // Output register: advance when empty or when the held transaction leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      payload_address <= res.grant ? grant_addr : '0;
      status          <= res.status;
    end
  end

  // Only a granted allocation carries an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_DONE) |-> payload_address == '0)
    else $error("failed transaction carries an address");

  // The engine takes no new transaction while a result is pending
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // A zero-size allocation answers in the next cycle
  a_zero_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_ALLOC) && (request_size == '0)
    |=> res.valid && (res.status == STAT_ZERO))
    else $error("zero-size allocation did not answer at once");

endmodule

// File: test/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit block allocator: directed cases, random traffic.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int MAX_BLOCKS    = DEF_MAX_BLOCKS;
  localparam int HEADER_BYTES  = DEF_HEADER_BYTES;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int WAIT_MAX      = 17;
  // The slowest transaction scans the whole table; allow that and a margin.
  localparam int IDLE_SETTLE   = MAX_BLOCKS + 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 240;
  localparam int STALL_ITEMS   = 40;
  localparam int STALL_CYCLES  = 600;
  localparam logic [OFF_W-1:0] HEAP_FULL_RANGE = 33'h1_0000_0000;

  // One awaited answer of the block.
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           code;
  } answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_ALLOC;
  logic [SIZE_W-1:0]    request_size = '0;
  logic [ADDR_W-1:0]    release_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    payload_address;
  logic [1:0]           status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEAP_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  // Shadow of the allocator: register copies, block list and heap top.
  logic [ADDR_W-1:0] heap_origin = '0;
  logic [OFF_W-1:0]  heap_ceiling = HEAP_BYTES_RESET;
  logic [OFF_W-1:0]  seg_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] seg_length [MAX_BLOCKS];
  bit                seg_busy [MAX_BLOCKS];
  int                seg_count = 0;
  logic [OFF_W-1:0]  heap_used = '0;

  answer_t awaited[$];
  int      mismatches = 0;
  int      cycle_count = 0;

  // Sender and receiver pacing.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int tx_gap = 0;
  bit valid_left_high = 1'b0;
  int ready_wait = 0;
  int hold_request = 0;
  int hold_left = 0;

  first_fit_block_allocator dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .request_size    (request_size),
    .release_address (release_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_address (payload_address),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------

  // Payload address of a block, always from the current base, wrapped to 48 bits.
  function automatic logic [ADDR_W-1:0] seg_address(int idx);
    logic [63:0] sum;
    sum = 64'(heap_origin) + 64'(seg_start[idx]) + 64'(HEADER_BYTES);
    return sum[ADDR_W-1:0];
  endfunction

  // First fit over the existing blocks, else append behind a header.
  function automatic answer_t predict_allocation(logic [SIZE_W-1:0] req);
    answer_t     ans;
    logic [33:0] rounded;
    logic [34:0] reach;
    int          i;
    ans.address = '0;
    ans.code    = STAT_SPACE;
    if (req == '0) begin
      ans.code = STAT_ZERO;
      return ans;
    end
    rounded = (34'(req) + 34'd7) & ~34'd7;
    // Rounding up to 2^32 leaves a length no block can hold
    if (rounded > 34'hFFFF_FFFF) return ans;
    for (i = 0; i < seg_count; i++) begin
      if (!seg_busy[i] && 34'(seg_length[i]) >= rounded) begin
        seg_busy[i] = 1'b1;
        ans.address = seg_address(i);
        ans.code    = STAT_DONE;
        return ans;
      end
    end
    if (seg_count >= MAX_BLOCKS) return ans;
    reach = 35'(heap_used) + 35'(HEADER_BYTES) + 35'(rounded);
    // Also refuses when the ceiling has been lowered below the heap top
    if (reach > 35'(heap_ceiling)) return ans;
    seg_start[seg_count]  = heap_used;
    seg_length[seg_count] = rounded[SIZE_W-1:0];
    seg_busy[seg_count]   = 1'b1;
    ans.address = seg_address(seg_count);
    ans.code    = STAT_DONE;
    seg_count++;
    heap_used = reach[OFF_W-1:0];
    return ans;
  endfunction

  // Free the first block whose payload address matches; zero is a no-op.
  function automatic answer_t predict_release(logic [ADDR_W-1:0] addr);
    answer_t ans;
    int      i;
    ans.address = '0;
    ans.code    = STAT_DONE;
    if (addr == '0) return ans;
    for (i = 0; i < seg_count; i++) begin
      if (seg_address(i) == addr) begin
        seg_busy[i] = 1'b0;
        return ans;
      end
    end
    ans.code = STAT_UNKNOWN;
    return ans;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] random_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly small sizes; now and then zero, full-range or close to 2^32.
  function automatic logic [SIZE_W-1:0] draw_size();
    int band;
    band = $urandom_range(0, 99);
    if (band < 60) return SIZE_W'($urandom_range(1, 256));
    if (band < 82) return SIZE_W'($urandom_range(257, 8192));
    if (band < 88) return '0;
    if (band < 94) return SIZE_W'($urandom);
    return 32'hFFFF_FFFF - SIZE_W'($urandom_range(0, 15));
  endfunction

  // Offer one transaction, hold it until accepted, then log its answer.
  task automatic send_request(cmd_t op, logic [SIZE_W-1:0] size,
                              logic [ADDR_W-1:0] addr);
    repeat (tx_gap) @(posedge clk);
    in_valid        <= 1'b1;
    command         <= op;
    request_size    <= size;
    release_address <= addr;
    do @(posedge clk); while (!in_ready);
    if (op == CMD_ALLOC) awaited.push_back(predict_allocation(size));
    else awaited.push_back(predict_release(addr));
    // Draw the gap now so valid is never dropped and raised in one step
    tx_gap = tx_idle ? $urandom_range(0, WAIT_MAX) : 0;
    valid_left_high = (tx_gap == 0);
    if (!valid_left_high) in_valid <= 1'b0;
  endtask

  // Drop valid, drain every awaited answer and let the engine settle.
  task automatic wait_until_idle();
    if (valid_left_high) begin
      in_valid <= 1'b0;
      valid_left_high = 1'b0;
    end
    while (awaited.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [ADDR_W-1:0] value);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) heap_origin = value;
    else heap_ceiling = value[OFF_W-1:0];
    @(posedge clk);
  endtask

  // One random transaction: mostly allocations and releases of real blocks.
  task automatic random_request();
    int                pick;
    int                idx;
    logic [SIZE_W-1:0] filler;
    filler = SIZE_W'($urandom);
    pick   = $urandom_range(0, 99);
    idx    = (seg_count > 0) ? $urandom_range(0, seg_count - 1) : 0;
    // Lean towards blocks still held, but keep some double releases
    if (seg_count > 0 && !seg_busy[idx] && $urandom_range(0, 3) != 0)
      idx = $urandom_range(0, seg_count - 1);
    if (pick < 55) begin
      send_request(CMD_ALLOC, draw_size(), random_address());
    end else if (pick < 88 && seg_count > 0) begin
      send_request(CMD_RELEASE, filler, seg_address(idx));
    end else if (pick < 93) begin
      send_request(CMD_RELEASE, filler, '0);
    end else if (pick < 96 && seg_count > 0) begin
      // Inside a block but not its payload address
      send_request(CMD_RELEASE, filler, seg_address(idx) + ADDR_W'(8));
    end else begin
      send_request(CMD_RELEASE, filler, random_address());
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_zero_size_and_rounding();
    send_request(CMD_ALLOC, '0, random_address());
    send_request(CMD_ALLOC, 32'd1, '0);
    send_request(CMD_ALLOC, '1, '1);
    send_request(CMD_ALLOC, 32'hFFFF_FFF8, '0);
    send_request(CMD_RELEASE, '1, '0);
    send_request(CMD_RELEASE, '0, '1);
  endtask

  task automatic test_first_fit_reuse();
    send_request(CMD_ALLOC, 32'd100, '0);
    send_request(CMD_RELEASE, '0, seg_address(0));
    send_request(CMD_RELEASE, '0, seg_address(0));
    send_request(CMD_ALLOC, 32'd8, '0);
    send_request(CMD_ALLOC, 32'd200, '0);
    send_request(CMD_RELEASE, '0, seg_address(1) + ADDR_W'(8));
  endtask

  task automatic test_base_change();
    // Base near the top: payload addresses wrap round 2^48
    write_register(REG_HEAP_BASE, 48'hFFFF_FFFF_FFF0);
    send_request(CMD_RELEASE, '0, seg_address(2));
    send_request(CMD_ALLOC, 32'd300, '0);
    write_register(REG_HEAP_BASE, random_address());
    send_request(CMD_RELEASE, '0, seg_address(seg_count - 1));
    send_request(CMD_ALLOC, 32'd16, '0);
  endtask

  task automatic test_heap_limit();
    int exact;
    write_register(REG_HEAP_BYTES, 48'(heap_used) + 48'(HEADER_BYTES + 64));
    send_request(CMD_ALLOC, 32'd64, '0);
    exact = seg_count - 1;
    send_request(CMD_ALLOC, 32'd1000, '0);
    // Ceiling below the heap top: old blocks stay usable, appends fail
    write_register(REG_HEAP_BYTES, '0);
    send_request(CMD_RELEASE, '0, seg_address(exact));
    send_request(CMD_ALLOC, 32'd64, '0);
    send_request(CMD_ALLOC, 32'd1000, '0);
    write_register(REG_HEAP_BYTES, 48'(HEAP_FULL_RANGE));
    send_request(CMD_ALLOC, 32'h8000_0000, '0);
    send_request(CMD_ALLOC, 32'hFFFF_FFF8, '0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(REG_HEAP_BASE, '1);
          write_register(REG_HEAP_BYTES,
                         48'(heap_used) + 48'($urandom_range(0, 8192)));
        end
        1: begin
          write_register(REG_HEAP_BASE, '0);
          write_register(REG_HEAP_BYTES, '0);
        end
        2: begin
          write_register(REG_HEAP_BASE, random_address());
          write_register(REG_HEAP_BYTES, 48'(HEAP_FULL_RANGE));
        end
        3: begin
          write_register(REG_HEAP_BASE, random_address());
          write_register(REG_HEAP_BYTES, 48'(HEAP_BYTES_RESET));
        end
        default: begin
          write_register(REG_HEAP_BASE, random_address());
          write_register(REG_HEAP_BYTES, 48'($urandom_range(0, 1 << 24)));
        end
      endcase
      // Vary pacing so some stretches run back to back
      tx_idle = (phase != 1) && (phase != 2);
      rx_idle = (phase != 1) && (phase != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender midway until every answer is back
        if (n == PHASE_ITEMS / 2) wait_until_idle();
        random_request();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Hold the output off for a long stretch while the sender keeps offering.
  task automatic test_output_stall();
    int n;
    wait_until_idle();
    tx_idle = 1'b0;
    hold_request = STALL_CYCLES;
    for (n = 0; n < STALL_ITEMS; n++) random_request();
    tx_idle = 1'b1;
  endtask

  task automatic test_table_full();
    bit refused;
    refused = 1'b0;
    write_register(REG_HEAP_BYTES, 48'(HEAP_FULL_RANGE));
    // Take every free block, then append until the list is full
    while (seg_count < MAX_BLOCKS && !refused) begin
      send_request(CMD_ALLOC, 32'd8, random_address());
      refused = (awaited[$].code == STAT_SPACE);
    end
    send_request(CMD_ALLOC, 32'hFFFF_FFF0, '0);
    send_request(CMD_ALLOC, 32'd8, '0);
  endtask

  // ---------------------------------------------------------------------
  // Result checking and output pacing
  // ---------------------------------------------------------------------

  function automatic void check_answer();
    answer_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: payload_address %h status %0d", payload_address, status);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (payload_address !== want.address) begin
      $error("payload_address: expected %h, got %h", want.address, payload_address);
      mismatches++;
    end
    if (status !== want.code) begin
      $error("status: expected %0d, got %0d", want.code, status);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_answer();
        ready_wait = rx_idle ? $urandom_range(0, WAIT_MAX) : 0;
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog and sequence
  // ---------------------------------------------------------------------

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_size_and_rounding();
    test_first_fit_reuse();
    test_base_change();
    test_heap_limit();
    test_random_traffic();
    test_output_stall();
    test_table_full();
    wait_until_idle();
    if (mismatches == 0) begin
      $display("[first_fit_block_allocator] OK");
    end else begin
      $display("[first_fit_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
